// ===== hdl/mh2_pkg.sv =====
// Package for the MurmurHash2 engine: constants, state and command types.
// Used by mh2_ctrl, mh2_datapath and murmur2_hash_engine; depends on nothing.
package mh2_pkg;

   localparam int unsigned HASH_W  = 32;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEN_W   = 31;
   localparam int unsigned PEND_W  = 24;
   localparam int unsigned FILL_W  = 2;

   // Mixing constants of the hash.
   localparam logic [HASH_W-1:0] MUR_M     = 32'h5bd1_e995;
   localparam int unsigned       MUR_R     = 24;
   localparam int unsigned       FIN_SHIFT1 = 13;
   localparam int unsigned       FIN_SHIFT2 = 15;

   // Fill level at which the next byte completes a word.
   localparam logic [FILL_W-1:0] FILL_LAST = 2'd3;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KMUL1,
      ST_KMUL2,
      ST_HMUL,
      ST_TAIL,
      ST_FIN1,
      ST_RESULT
   } state_type;

   // Datapath operations issued by the controller.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_KMUL1,
      OP_KMUL2,
      OP_HMUL,
      OP_TAIL,
      OP_FIN1,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic word_done;  // accepted request completes a four-byte word
      logic rsp_busy;   // output register holds a result that is stalled
   } status_type;

endpackage

// ===== hdl/murmur2_hash_engine.sv =====
// Top level of the streaming MurmurHash2 engine.
// Depends on mh2_pkg, mh2_ctrl and mh2_datapath.
//
//   Channel  Direction  Handshake           Content
//   req      in         req_valid/req_stall  one key byte, length, first, last
//   rsp      out        rsp_valid/rsp_stall  32-bit hash and length mismatch
//   csr      in         csr_valid/csr_ready  hash seed
//
// A byte that does not complete a word is only packed. A byte that completes
// a word stalls requests while the single shared 32-bit multiplier runs the
// three multiplies of the word mix one after another. A last request then
// runs the tail multiply and the final avalanche, and waits while the
// output register stays stalled.
// Reset is synchronous; it clears the seed and the hash state to zero.
// Requests are taken while a finished result waits in the output register.
module murmur2_hash_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mh2_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic [mh2_pkg::LEN_W-1:0]   req_key_length,
   input  logic                        req_first,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mh2_pkg::HASH_W-1:0]  rsp_hash_value,
   output logic                        rsp_length_mismatch,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [mh2_pkg::HASH_W-1:0]  csr_hash_seed
);

   mh2_pkg::cmd_type    cmd;
   mh2_pkg::status_type status;

   // The seed register takes a write in any cycle.
   assign csr_ready = 1'b1;

   mh2_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mh2_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_data_byte       (req_data_byte),
      .req_key_length      (req_key_length),
      .req_first           (req_first),
      .req_last            (req_last),
      .csr_valid           (csr_valid),
      .csr_hash_seed       (csr_hash_seed),
      .rsp_hash_value      (rsp_hash_value),
      .rsp_length_mismatch (rsp_length_mismatch),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall)
   );

endmodule

// ===== hdl/mh2_ctrl.sv =====
// Controller state machine for the MurmurHash2 engine.
// Depends on mh2_pkg; drives the datapath through mh2_pkg::cmd_type.
module mh2_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_stall,
   input  mh2_pkg::status_type status,
   output mh2_pkg::cmd_type    cmd
);

   mh2_pkg::state_type state_ff, state_in;
   logic               last_ff, last_in;

   // Next state: a word mix takes three multiply steps, a key end two more and a result step.
   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      unique case (state_ff)
         mh2_pkg::ST_IDLE: begin
            if (req_valid) begin
               last_in = req_last;
               if (status.word_done) begin
                  state_in = mh2_pkg::ST_KMUL1;
               end else if (req_last) begin
                  state_in = mh2_pkg::ST_TAIL;
               end
            end
         end
         mh2_pkg::ST_KMUL1: state_in = mh2_pkg::ST_KMUL2;
         mh2_pkg::ST_KMUL2: state_in = mh2_pkg::ST_HMUL;
         mh2_pkg::ST_HMUL: begin
            state_in = last_ff ? mh2_pkg::ST_TAIL : mh2_pkg::ST_IDLE;
         end
         mh2_pkg::ST_TAIL: state_in = mh2_pkg::ST_FIN1;
         mh2_pkg::ST_FIN1: state_in = mh2_pkg::ST_RESULT;
         mh2_pkg::ST_RESULT: begin
            if (!status.rsp_busy) begin
               state_in = mh2_pkg::ST_IDLE;
            end
         end
         default: state_in = mh2_pkg::ST_IDLE;
      endcase
   end

   // Outputs: one datapath operation per state.
   always_comb begin
      req_stall = 1'b1;
      cmd.op    = mh2_pkg::OP_NONE;
      unique case (state_ff)
         mh2_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op = mh2_pkg::OP_ACCEPT;
            end
         end
         mh2_pkg::ST_KMUL1: cmd.op = mh2_pkg::OP_KMUL1;
         mh2_pkg::ST_KMUL2: cmd.op = mh2_pkg::OP_KMUL2;
         mh2_pkg::ST_HMUL:  cmd.op = mh2_pkg::OP_HMUL;
         mh2_pkg::ST_TAIL:  cmd.op = mh2_pkg::OP_TAIL;
         mh2_pkg::ST_FIN1:  cmd.op = mh2_pkg::OP_FIN1;
         mh2_pkg::ST_RESULT: begin
            if (!status.rsp_busy) begin
               cmd.op = mh2_pkg::OP_RESULT;
            end
         end
         default: cmd.op = mh2_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mh2_pkg::ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule

// ===== hdl/mh2_datapath.sv =====
// Datapath of the MurmurHash2 engine: byte packing, shared multiplier,
// hash state, seed register and result register. Depends on mh2_pkg.
module mh2_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  mh2_pkg::cmd_type                    cmd,
   output mh2_pkg::status_type                 status,
   input  logic [mh2_pkg::BYTE_W-1:0]          req_data_byte,
   input  logic [mh2_pkg::LEN_W-1:0]           req_key_length,
   input  logic                                req_first,
   input  logic                                req_last,
   input  logic                                csr_valid,
   input  logic [mh2_pkg::HASH_W-1:0]          csr_hash_seed,
   output logic [mh2_pkg::HASH_W-1:0]          rsp_hash_value,
   output logic                                rsp_length_mismatch,
   output logic                                rsp_valid,
   input  logic                                rsp_stall
);

   logic [mh2_pkg::HASH_W-1:0] seed_ff;
   logic [mh2_pkg::HASH_W-1:0] hash_ff, hash_in;
   logic [mh2_pkg::HASH_W-1:0] word_ff, word_in;
   logic [mh2_pkg::PEND_W-1:0] pend_ff, pend_in;
   logic [mh2_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [mh2_pkg::LEN_W-1:0]  seen_ff, seen_in;
   logic [mh2_pkg::LEN_W-1:0]  announced_ff, announced_in;
   logic                       mismatch_ff, mismatch_in;
   logic [mh2_pkg::HASH_W-1:0] rsp_hash_ff;
   logic                       rsp_mismatch_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [mh2_pkg::HASH_W-1:0] base_hash;
   logic [mh2_pkg::PEND_W-1:0] base_pend;
   logic [mh2_pkg::FILL_W-1:0] base_fill;
   logic [mh2_pkg::LEN_W-1:0]  base_seen;
   logic [mh2_pkg::LEN_W-1:0]  base_announced;
   logic                       take;
   logic [mh2_pkg::HASH_W-1:0] mul_a;
   logic [mh2_pkg::HASH_W-1:0] product;
   logic                       tail_present;

   // Starting point of an accepted request: a first request opens a new key.
   always_comb begin
      if (req_first) begin
         base_hash      = seed_ff ^ {1'b0, req_key_length};
         base_pend      = '0;
         base_fill      = '0;
         base_seen      = '0;
         base_announced = req_key_length;
      end else begin
         base_hash      = hash_ff;
         base_pend      = pend_ff;
         base_fill      = fill_ff;
         base_seen      = seen_ff;
         base_announced = announced_ff;
      end
   end

   // An empty key carries no byte.
   assign take = !(req_first && req_last && (req_key_length == '0));

   assign status.word_done = take && (base_fill == mh2_pkg::FILL_LAST);
   assign status.rsp_busy  = rsp_valid_ff && rsp_stall;
   assign tail_present     = (fill_ff != '0);

   // Shared multiplier operand, one multiply by the constant per step.
   always_comb begin
      unique case (cmd.op)
         mh2_pkg::OP_KMUL2: mul_a = word_ff ^ (word_ff >> mh2_pkg::MUR_R);
         mh2_pkg::OP_HMUL:  mul_a = hash_ff;
         mh2_pkg::OP_TAIL:  mul_a = hash_ff ^ {{(mh2_pkg::HASH_W-mh2_pkg::PEND_W){1'b0}}, pend_ff};
         mh2_pkg::OP_FIN1:  mul_a = hash_ff ^ (hash_ff >> mh2_pkg::FIN_SHIFT1);
         default:           mul_a = word_ff;
      endcase
   end

   assign product = mul_a * mh2_pkg::MUR_M;

   // Next values of the hash state.
   always_comb begin
      hash_in      = hash_ff;
      word_in      = word_ff;
      pend_in      = pend_ff;
      fill_in      = fill_ff;
      seen_in      = seen_ff;
      announced_in = announced_ff;
      mismatch_in  = mismatch_ff;
      unique case (cmd.op)
         mh2_pkg::OP_ACCEPT: begin
            hash_in      = base_hash;
            pend_in      = base_pend;
            fill_in      = base_fill;
            seen_in      = base_seen;
            announced_in = base_announced;
            if (take) begin
               if (base_fill == mh2_pkg::FILL_LAST) begin
                  word_in = {req_data_byte, base_pend};
                  pend_in = '0;
                  fill_in = '0;
               end else begin
                  pend_in = base_pend
                          | ({{(mh2_pkg::PEND_W-mh2_pkg::BYTE_W){1'b0}}, req_data_byte}
                             << {base_fill, 3'b000});
                  fill_in = base_fill + 1'b1;
               end
               seen_in = base_seen + 1'b1;
            end
            mismatch_in = (seen_in != announced_in);
         end
         mh2_pkg::OP_KMUL1, mh2_pkg::OP_KMUL2: begin
            word_in = product;
         end
         mh2_pkg::OP_HMUL: begin
            hash_in = product ^ word_ff;
         end
         mh2_pkg::OP_TAIL: begin
            if (tail_present) begin
               hash_in = product;
            end
         end
         mh2_pkg::OP_FIN1: begin
            hash_in = product;
         end
         mh2_pkg::OP_RESULT: begin
            hash_in      = '0;
            pend_in      = '0;
            fill_in      = '0;
            seen_in      = '0;
            announced_in = '0;
         end
         default: begin
            hash_in = hash_ff;
         end
      endcase
   end

   // Result register is freed when taken and loaded on a finished key.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.op == mh2_pkg::OP_RESULT) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         hash_ff      <= '0;
         pend_ff      <= '0;
         fill_ff      <= '0;
         seen_ff      <= '0;
         announced_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            seed_ff <= csr_hash_seed;
         end
         hash_ff      <= hash_in;
         pend_ff      <= pend_in;
         fill_ff      <= fill_in;
         seen_ff      <= seen_in;
         announced_ff <= announced_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      mismatch_ff <= mismatch_in;
      if (cmd.op == mh2_pkg::OP_RESULT) begin
         rsp_hash_ff     <= hash_ff ^ (hash_ff >> mh2_pkg::FIN_SHIFT2);
         rsp_mismatch_ff <= mismatch_ff;
      end
   end

   assign rsp_hash_value      = rsp_hash_ff;
   assign rsp_length_mismatch = rsp_mismatch_ff;
   assign rsp_valid           = rsp_valid_ff;

endmodule
